// ----- src/pdf_pkg.sv -----
`default_nettype none

package pdf_pkg;

    // Row geometry and store size
    localparam int NODES     = 16;
    localparam int MAX_PATHS = 64;
    localparam int ID_W      = 5;
    localparam int END_W     = 4;
    localparam int IDX_W     = $clog2(NODES);

    // Pattern of an unused row position (-1)
    localparam logic [ID_W-1:0] UNUSED_ID = '1;

    typedef logic signed [ID_W-1:0]       node_t;
    typedef logic [NODES-1:0][ID_W-1:0]   row_t;

    typedef struct packed {
        node_t in_node;
        logic  row_end;
        logic  new_set;
    } in_item_t;

    typedef struct packed {
        node_t out_node;
        logic  row_last;
        logic  overflow;
    } out_item_t;

    // Broadcast from the row controller to every store cell
    typedef struct packed {
        logic             accept;
        logic             first;
        logic             fresh;
        logic             row_done;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  val;
        logic             push;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/pdf_cell.sv -----
`default_nettype none

module pdf_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  pdf_pkg::cell_ctl_t ctl,
    input  pdf_pkg::row_t     row_in,
    input  logic              valid_in,
    output pdf_pkg::row_t     row_out,
    output logic              valid_out,
    output logic              match
);
    import pdf_pkg::*;

    row_t row_reg;
    logic valid_reg;
    logic match_reg;
    logic match_next;
    logic base;
    logic elem_eq;
    logic pad_ok;

    // Compare the incoming element and, at row end, the padded tail
    always_comb
    begin
        pad_ok = 1'b1;
        for (int p = 0; p < NODES; p++)
        begin
            if (p > int'(ctl.idx) && row_reg[p] != UNUSED_ID)
                pad_ok = 1'b0;
        end
        elem_eq    = (row_reg[ctl.idx] == ctl.val);
        base       = ctl.first ? (valid_reg && !ctl.fresh) : match_reg;
        match_next = base && elem_eq && (!ctl.row_done || pad_ok);
    end

    // Hold valid and match flags; clear on a new set, shift on push
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.accept && ctl.first && ctl.fresh)
                valid_reg <= 1'b0;
            else if (ctl.push)
                valid_reg <= valid_in;
            if (ctl.accept)
                match_reg <= match_next;
        end
    end

    // Take the neighbor's row on push
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            row_reg <= row_in;
    end

    assign row_out   = row_reg;
    assign valid_out = valid_reg;
    assign match     = match_reg;

endmodule

`default_nettype wire

// ----- src/pdf_emit.sv -----
`default_nettype none

module pdf_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pdf_pkg::row_t      row,
    input  logic               ovf,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_stall,
    output pdf_pkg::out_item_t out_data
);
    import pdf_pkg::*;

    row_t             row_reg;
    logic             ovf_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;
    logic             advance;
    logic             at_last;

    assign advance = busy_reg && (!out_valid_reg || !out_stall);
    assign at_last = (cnt_reg == IDX_W'(NODES - 1));

    // Control: busy flag, element count, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (advance)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (at_last)
                    busy_reg <= 1'b0;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: shift the row out one element per transaction
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= row;
            ovf_reg <= ovf;
        end
        else if (advance)
        begin
            row_reg <= row_reg >> ID_W;
        end
        if (advance)
        begin
            out_data_reg.out_node <= node_t'(row_reg[0]);
            out_data_reg.row_last <= at_last;
            out_data_reg.overflow <= ovf_reg;
        end
    end

    assign busy      = busy_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A new row is never loaded over one still being sent
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy_reg)
        else $error("emitter loaded while busy");

    // The emitter goes idle exactly as the final element is registered
    a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (out_valid_reg && out_data_reg.row_last))
        else $error("emitter finished without a row_last element");

endmodule

`default_nettype wire

// ----- src/path_dedup_filter.sv -----
// path_dedup_filter: keeps unique graph paths that pass through end_node.
//
// Input channel (in_valid/in_stall/in_data): one row element per transaction,
// row_end on the last element, new_set on a row's first element empties the
// store. A row stops by itself after NODES elements; a short row is padded
// with -1. Output channel (out_valid/out_stall/out_data): every kept row is
// sent as NODES transactions, row_last on the final one, overflow on all of
// them when the store of MAX_PATHS rows was already full.
// Throughput: one element per cycle, but the input is held in a decision
// state after every row end, and a kept row holds it there until the emitter
// is free: the emitter takes no new row before the last one is all sent. A
// kept row's last element is registered in the row buffer, the decision
// state loads the emitter, and the emitter registers the first element out.
// Each stored row sits in its own cell and compares the incoming element in
// parallel; a kept row shifts into the head of the cell chain. Reset empties
// the store and sets end_node to 0.
// A stalled receiver holds the output register and the emitter; input is
// still taken until the next kept row needs the emitter.
// cfg_we writes end_node from cfg_wdata; write it only while idle.
`default_nettype none

module path_dedup_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pdf_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pdf_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [pdf_pkg::END_W-1:0]      cfg_wdata
);
    import pdf_pkg::*;

    typedef enum logic {
        S_COLLECT,
        S_DECIDE
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             saw_end_reg;
    logic [END_W-1:0] end_node_reg;
    row_t             row_buf_reg;

    logic             accept;
    logic             first;
    logic             row_done;
    logic             hit;
    logic             any_match;
    logic             keep;
    logic             full;
    logic             emit_busy;
    logic             emit_load;
    logic             push;
    cell_ctl_t        ctl;

    row_t             cell_row   [MAX_PATHS];
    logic             cell_valid [MAX_PATHS];
    logic [MAX_PATHS-1:0] match_vec;

    assign in_stall  = (state_reg != S_COLLECT);
    assign accept    = in_valid && !in_stall;
    assign first     = (idx_reg == '0);
    assign row_done  = in_data.row_end || (idx_reg == IDX_W'(NODES - 1));
    assign hit       = !in_data.in_node[ID_W-1] &&
                       (in_data.in_node[END_W-1:0] == end_node_reg);
    assign any_match = |match_vec;
    assign keep      = saw_end_reg && !any_match;
    assign full      = cell_valid[MAX_PATHS-1];
    assign emit_load = (state_reg == S_DECIDE) && keep && !emit_busy;
    assign push      = emit_load && !full;

    // Broadcast element and control to the cell chain
    always_comb
    begin
        ctl.accept   = accept;
        ctl.first    = first;
        ctl.fresh    = in_data.new_set;
        ctl.row_done = row_done;
        ctl.idx      = idx_reg;
        ctl.val      = in_data.in_node;
        ctl.push     = push;
    end

    // Row sequencing: collect elements, then decide keep or drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_COLLECT;
            idx_reg     <= '0;
            saw_end_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_COLLECT:
                begin
                    if (accept)
                    begin
                        saw_end_reg <= first ? hit : (saw_end_reg || hit);
                        if (row_done)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (!keep || !emit_busy)
                        state_reg <= S_COLLECT;
                end
                default:
                begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            end_node_reg <= '0;
        else if (cfg_we)
            end_node_reg <= cfg_wdata;
    end

    // Assemble the row in progress; pad the tail at row end
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int p = 0; p < NODES; p++)
            begin
                if (p == int'(idx_reg))
                    row_buf_reg[p] <= in_data.in_node;
                else if (row_done && p > int'(idx_reg))
                    row_buf_reg[p] <= UNUSED_ID;
            end
        end
    end

    // Chain of store cells; a kept row enters at cell 0
    for (genvar i = 0; i < MAX_PATHS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            pdf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .row_in    (row_buf_reg),
                .valid_in  (1'b1),
                .row_out   (cell_row[i]),
                .valid_out (cell_valid[i]),
                .match     (match_vec[i])
            );
        end
        else
        begin : g_body
            pdf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .row_in    (cell_row[i-1]),
                .valid_in  (cell_valid[i-1]),
                .row_out   (cell_row[i]),
                .valid_out (cell_valid[i]),
                .match     (match_vec[i])
            );
        end
    end

    pdf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .row       (row_buf_reg),
        .ovf       (full),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Input is held in the decision state after every row end
    a_decide_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_done) |=> in_stall)
        else $error("input taken during row decision");

    // Every row restarts at position zero
    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_done) |=> (idx_reg == '0))
        else $error("element index not cleared at row end");

    // An overflow row leaves a full store full
    a_full_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && full) |=> full)
        else $error("full store changed by an overflow row");

endmodule

`default_nettype wire

// ----- tb/path_dedup_filter_test.sv -----
module path_dedup_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pdf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               cfg_we    = 1'b0;
    logic [END_W-1:0]   cfg_wdata = '0;

    int sender_idle_pct    = 21;
    int receiver_stall_pct = 84;
    int err_count          = 0;
    int cycle_count        = 0;

    // Mirror of the filter: kept paths, path in progress, configured end node
    logic [ID_W-1:0]      kept_paths [MAX_PATHS][NODES];
    int                   kept_total   = 0;
    logic [ID_W-1:0]      path_buf [NODES];
    int                   path_pos     = 0;
    bit                   path_has_end = 1'b0;
    logic [MAX_PATHS-1:0] still_equal  = '0;
    logic [END_W-1:0]     end_sel      = '0;

    out_item_t echo_queue [$];
    row_t      path_history [$];

    path_dedup_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Place one id in the path and clear the match flag of every kept path that differs there
    function automatic void place_id(int p, logic [ID_W-1:0] v);
        path_buf[p] = v;
        if (v == {1'b0, end_sel})
            path_has_end = 1'b1;
        for (int r = 0; r < kept_total; r++)
            if (kept_paths[r][p] != v)
                still_equal[r] = 1'b0;
    endfunction

    // Advance the mirror by one accepted element; queue the echo of a kept path
    function automatic void dedup_element(in_item_t it);
        bit        store_full;
        out_item_t o;
        if (path_pos == 0)
        begin
            if (it.new_set)
                kept_total = 0;
            still_equal = '0;
            for (int r = 0; r < kept_total; r++)
                still_equal[r] = 1'b1;
            path_has_end = 1'b0;
        end
        place_id(path_pos, it.in_node);
        if (!it.row_end && path_pos + 1 < NODES)
        begin
            path_pos++;
            return;
        end
        for (int p = path_pos + 1; p < NODES; p++)
            place_id(p, UNUSED_ID);
        path_pos = 0;
        if (!path_has_end || still_equal != '0)
            return;
        store_full = (kept_total >= MAX_PATHS);
        if (!store_full)
        begin
            for (int p = 0; p < NODES; p++)
                kept_paths[kept_total][p] = path_buf[p];
            kept_total++;
        end
        for (int p = 0; p < NODES; p++)
        begin
            o.out_node = path_buf[p];
            o.row_last = (p == NODES - 1);
            o.overflow = store_full;
            echo_queue.push_back(o);
        end
    endfunction

    // Track input transactions and check every output transaction in order
    always @(posedge clk)
    begin : check_echo
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                dedup_element(in_data);
            if (out_valid && !out_stall)
            begin
                if (echo_queue.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("%0t: unexpected output: expected none, actual %0d/%b/%b",
                                 $time, out_data.out_node, out_data.row_last,
                                 out_data.overflow);
                end
                else
                begin
                    want = echo_queue.pop_front();
                    if (out_data.out_node !== want.out_node ||
                        out_data.row_last !== want.row_last ||
                        out_data.overflow !== want.overflow)
                    begin
                        err_count++;
                        if (err_count <= MAX_SHOWN)
                            $display("%0t: mismatch: expected %0d/%b/%b, actual %0d/%b/%b",
                                     $time, want.out_node, want.row_last, want.overflow,
                                     out_data.out_node, out_data.row_last,
                                     out_data.overflow);
                    end
                end
            end
        end
    end

    // Stall the output at random
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time, echo_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Send one element, idling at random, hold it until the transaction completes
    task automatic send_element(in_item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Send the first len ids of a path; close_full marks row_end on a full path
    task automatic send_row(row_t ids, int len, bit fresh, bit late_fresh, bit close_full);
        in_item_t it;
        for (int p = 0; p < len; p++)
        begin
            it.in_node = ids[p];
            it.row_end = (p == len - 1) && (len < NODES || close_full);
            it.new_set = (p == 0) ? fresh : (late_fresh && $urandom_range(0, 1));
            send_element(it);
        end
    endtask

    // Hold the input until every expected echo is out and the block is quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (echo_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_end_node(logic [END_W-1:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        end_sel    = v;
    endtask

    task automatic test_directed_rows();
        row_t r;
        write_end_node(4'd15);
        // one-element path with the end node on a new set: kept
        r    = {NODES{UNUSED_ID}};
        r[0] = 5'd15;
        send_row(r, 1, 1'b1, 1'b0, 1'b0);
        // explicit -1 equals the padding: duplicate, dropped
        send_row(r, 2, 1'b0, 1'b0, 1'b0);
        // end node in second position: kept
        r[0] = 5'd3;
        r[1] = 5'd15;
        send_row(r, 2, 1'b0, 1'b0, 1'b0);
        // no end node: dropped
        r[0] = 5'd1;
        r[1] = 5'd2;
        send_row(r, 2, 1'b0, 1'b0, 1'b0);
        // ids below -1 pass through as raw patterns
        r[0] = 5'b10000;
        r[1] = 5'd15;
        r[2] = 5'b11110;
        send_row(r, 3, 1'b0, 1'b0, 1'b0);
        // long path closes by itself; new_set after the first element is ignored
        for (int p = 0; p < NODES; p++)
            r[p] = ID_W'(NODES - 1 - p);
        send_row(r, NODES, 1'b0, 1'b1, 1'b0);
        // lowest end node on a new set
        write_end_node(4'd0);
        r    = {NODES{UNUSED_ID}};
        r[0] = 5'd0;
        send_row(r, 1, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_store_overflow();
        row_t r;
        row_t dup;
        int   len;
        write_end_node(4'd9);
        // fill the store with two-id paths (every id after the end node, then
        // before it, one repeat among them), then overflow it with three-id paths
        for (int i = 0; i < MAX_PATHS + 4; i++)
        begin
            r   = {NODES{UNUSED_ID}};
            len = 2;
            if (i < 32)
            begin
                r[0] = 5'd9;
                r[1] = ID_W'(i);
            end
            else if (i < 64)
            begin
                r[0] = ID_W'(i);
                r[1] = 5'd9;
            end
            else
            begin
                r[0] = 5'd9;
                r[1] = ID_W'(i);
                r[2] = 5'd0;
                len  = 3;
            end
            send_row(r, len, i == 0, 1'b0, 1'b0);
        end
        // stored path while full: dropped
        dup    = {NODES{UNUSED_ID}};
        dup[0] = 5'd9;
        dup[1] = 5'd5;
        send_row(dup, 2, 1'b0, 1'b0, 1'b0);
        // overflowed path was never stored: echoed again with overflow
        send_row(r, 3, 1'b0, 1'b0, 1'b0);
        // new set empties the full store
        send_row(r, 3, 1'b1, 1'b0, 1'b0);
    endtask

    // Mostly paths through the end node, many replays of earlier paths, some noise
    task automatic test_random_rows(int budget);
        row_t r;
        int   sent;
        int   len;
        int   pick;
        int   top;
        bit   paused;
        sent   = 0;
        paused = 1'b0;
        write_end_node(4'($urandom_range(0, 15)));
        while (sent < budget)
        begin
            if (!paused && sent >= budget / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            r    = {NODES{UNUSED_ID}};
            if (pick < 30 && path_history.size() != 0)
            begin
                // replay, possibly with explicit -1 in place of padding
                r   = path_history[$urandom_range(0, path_history.size() - 1)];
                top = 0;
                for (int p = 0; p < NODES; p++)
                    if (r[p] != UNUSED_ID)
                        top = p + 1;
                len = $urandom_range((top > 0) ? top : 1, (top + 3 < NODES) ? top + 3 : NODES);
            end
            else
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NODES)
                                                  : $urandom_range(1, 5);
                for (int p = 0; p < len; p++)
                    case ($urandom_range(0, 4))
                        0:       r[p] = ID_W'($urandom_range(0, 31));
                        1:       r[p] = UNUSED_ID;
                        2:       r[p] = {1'b0, end_sel};
                        default: r[p] = ID_W'($urandom_range(0, 3));
                    endcase
                if (pick >= 45)
                    r[$urandom_range(0, len - 1)] = {1'b0, end_sel};
                if (path_history.size() < 32)
                    path_history.push_back(r);
                else
                    path_history[$urandom_range(0, 31)] = r;
            end
            send_row(r, len, $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0,
                     $urandom_range(0, 1) == 1);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_rows();
        test_random_rows(12);

        sender_idle_pct    = 84;
        receiver_stall_pct = 21;
        test_store_overflow();
        test_random_rows(6);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_rows(12);

        drain_results();
        repeat (16) @(posedge clk);
        if (err_count == 0 && echo_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
